### hdl/pidr_pkg.sv
// Shared types and constants for the ramp-limited PID controller.
// Depends on nothing; used by pidr_mul_div and pid_controller_ramp_limited.
`timescale 1ns / 1ps
`default_nettype none

package pidr_pkg;

  // Wide intermediate format: signed 64 bits, magnitudes saturate at 2^60-1.
  localparam int WIDE_W = 64;
  localparam int MAG_W  = 61;
  localparam int SAT_W  = 60;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DEN_W  = 21;
  localparam int CNT_W  = $clog2(MAG_W + 1);
  localparam int TS_W   = 32;
  localparam int DT_W   = 19;

  localparam logic [TS_W-1:0]  MAX_GAP_US     = 32'd500000;
  localparam logic [DT_W-1:0]  DEFAULT_GAP_US = 19'd1000;
  localparam logic [DEN_W-1:0] US_PER_SEC     = 21'd1000000;
  localparam logic [DEN_W-1:0] TWO_US_PER_SEC = 21'd2000000;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_RAMP   = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  typedef struct packed {
    logic start;
    logic is_div;      // 0: saturating multiply, 1: truncating divide
    logic shift_frac;  // multiply only: drop FRAC_BITS from the product
  } pidr_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;        // one-cycle pulse, result valid
  } pidr_stat_t;

  function automatic logic signed [WIDE_W-1:0] clamp_sym(
    input logic signed [WIDE_W-1:0] v,
    input logic signed [WIDE_W-1:0] lim
  );
    logic signed [WIDE_W-1:0] r;
    r = v;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/pid_controller_ramp_limited.sv
// Ramp-limited PID controller, top level: stream ports, config registers, sequencer.
// Depends on pidr_pkg and pidr_mul_div.
`timescale 1ns / 1ps
`default_nettype none

// Signed fixed-point PID controller with trapezoidal integral, derivative over the
// elapsed time, symmetric output clamp and optional output ramp limit. Each input
// transaction carries an error sample and a microsecond timestamp; each produces one
// drive transaction. All products and quotients run through one shared bit-serial
// unit; each operation is a load, 61 one-bit steps and a finish, after which the
// sequencer captures the result. An item needs seven such operations, nine with ramp
// limiting on, plus the sum, ramp and output states; that serial unit sets the rate.
// One item is worked on at a time. The drive output register holds a finished result
// until it is taken, and the next input transaction is accepted meanwhile. Config
// writes are taken at any time and must only be made while the block is idle.
module pid_controller_ramp_limited #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16,
  localparam int IN_W  = ((DATA_WIDTH + 32 + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_idx_i,
  input  wire logic [DATA_WIDTH-1:0] cfg_wdata_i,
  // input stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_W-1:0]       s_axis_tdata_i,  // error, timestamp[31:0]
  // output stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]           m_axis_tdata_o   // drive
);
  import pidr_pkg::*;

  localparam int DW = DATA_WIDTH;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_P    = 13'b0000000000010,
    S_I1   = 13'b0000000000100,
    S_I2   = 13'b0000000001000,
    S_I3   = 13'b0000000010000,
    S_D1   = 13'b0000000100000,
    S_D2   = 13'b0000001000000,
    S_D3   = 13'b0000010000000,
    S_SUM  = 13'b0000100000000,
    S_R1   = 13'b0001000000000,
    S_R2   = 13'b0010000000000,
    S_RAMP = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  // config registers
  logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [DW-2:0]        ramp_q, limit_q;

  // controller state
  logic signed [DW-1:0] last_error_q, last_drive_q, integ_sum_q;
  logic [TS_W-1:0]      last_time_q;

  // per-item working registers
  logic signed [DW-1:0]     err_q;
  logic [TS_W-1:0]          ts_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [DW:0]       esum_q, ediff_q;
  logic signed [WIDE_W-1:0] p_q, t_q, integ_q, d_q, drive_q, step_q;
  logic signed [WIDE_W-1:0] p_d, t_d, integ_d, d_d, drive_d, step_d;

  logic signed [DW-1:0] out_q;
  logic                 out_valid_q;

  // arithmetic unit
  pidr_cmd_t                cmd;
  pidr_stat_t               stat;
  logic signed [WIDE_W-1:0] op_a, op_b, unit_res;
  logic                     unit_start;

  logic signed [DW-1:0] in_err;
  logic [TS_W-1:0]      in_ts, gap;
  logic [DT_W-1:0]      dt_sel;
  logic                 in_acc, out_load;
  logic signed [WIDE_W-1:0] lim_w, delta;

  assign in_err = s_axis_tdata_i[DW-1:0];
  assign in_ts  = s_axis_tdata_i[DW+TS_W-1:DW];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // elapsed time with wrap; an empty or overlong gap counts as the default gap
  always_comb begin
    gap    = in_ts - last_time_q;
    dt_sel = (gap == '0 || gap > MAX_GAP_US) ? DEFAULT_GAP_US : gap[DT_W-1:0];
  end

  assign lim_w = WIDE_W'(signed'({1'b0, limit_q}));
  assign delta = drive_q - WIDE_W'(last_drive_q);

  // operand routing for the shared unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    cmd.start      = unit_start;
    cmd.is_div     = 1'b0;
    cmd.shift_frac = 1'b0;
    unique case (state_q)
      S_P: begin
        op_a = WIDE_W'(gain_p_q);
        op_b = WIDE_W'(err_q);
        cmd.shift_frac = 1'b1;
      end
      S_I1: begin
        op_a = WIDE_W'(gain_i_q);
        op_b = WIDE_W'(esum_q);
        cmd.shift_frac = 1'b1;
      end
      S_I2: begin
        op_a = t_q;
        op_b = WIDE_W'(dt_q);
      end
      S_I3: begin
        op_a = t_q;
        op_b = WIDE_W'(TWO_US_PER_SEC);
        cmd.is_div = 1'b1;
      end
      S_D1: begin
        op_a = WIDE_W'(gain_d_q);
        op_b = WIDE_W'(ediff_q);
        cmd.shift_frac = 1'b1;
      end
      S_D2: begin
        op_a = t_q;
        op_b = WIDE_W'(US_PER_SEC);
      end
      S_D3: begin
        op_a = t_q;
        op_b = WIDE_W'(dt_q);
        cmd.is_div = 1'b1;
      end
      S_R1: begin
        op_a = WIDE_W'(signed'({1'b0, ramp_q}));
        op_b = WIDE_W'(dt_q);
      end
      S_R2: begin
        op_a = t_q;
        op_b = WIDE_W'(US_PER_SEC);
        cmd.is_div = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pidr_mul_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .a_i    (op_a),
    .b_i    (op_b),
    .stat_o (stat),
    .res_o  (unit_res)
  );

  // sequencer: each arithmetic state issues once, then waits for done
  always_comb begin
    state_d    = state_q;
    issued_d   = issued_q;
    unit_start = 1'b0;
    p_d        = p_q;
    t_d        = t_q;
    integ_d    = integ_q;
    d_d        = d_q;
    drive_d    = drive_q;
    step_d     = step_q;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_P;
      end
      S_P, S_I1, S_I2, S_I3, S_D1, S_D2, S_D3, S_R1, S_R2: begin
        if (!issued_q) begin
          unit_start = 1'b1;
          issued_d   = 1'b1;
        end else if (stat.done) begin
          issued_d = 1'b0;
          t_d      = unit_res;
          unique case (state_q)
            S_P:  begin p_d = unit_res; state_d = S_I1; end
            S_I1: state_d = S_I2;
            S_I2: state_d = S_I3;
            S_I3: begin
              integ_d = clamp_sym(WIDE_W'(integ_sum_q) + unit_res, lim_w);
              state_d = S_D1;
            end
            S_D1: state_d = S_D2;
            S_D2: state_d = S_D3;
            S_D3: begin d_d = unit_res; state_d = S_SUM; end
            S_R1: state_d = S_R2;
            default: begin step_d = unit_res; state_d = S_RAMP; end
          endcase
        end
      end
      S_SUM: begin
        drive_d = clamp_sym(p_q + integ_q + d_q, lim_w);
        state_d = (ramp_q != '0) ? S_R1 : S_OUT;
      end
      S_RAMP: begin
        if (delta > step_q) drive_d = WIDE_W'(last_drive_q) + step_q;
        else if (delta < -step_q) drive_d = WIDE_W'(last_drive_q) - step_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issued_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      gain_p_q     <= '0;
      gain_i_q     <= '0;
      gain_d_q     <= '0;
      ramp_q       <= '0;
      limit_q      <= '0;
      last_error_q <= '0;
      last_drive_q <= '0;
      integ_sum_q  <= '0;
      last_time_q  <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GAIN_P: gain_p_q <= cfg_wdata_i;
          REG_GAIN_I: gain_i_q <= cfg_wdata_i;
          REG_GAIN_D: gain_d_q <= cfg_wdata_i;
          REG_RAMP:   ramp_q   <= cfg_wdata_i[DW-2:0];
          REG_LIMIT:  limit_q  <= cfg_wdata_i[DW-2:0];
          default: begin
          end
        endcase
      end
      if (out_load) begin
        integ_sum_q  <= integ_q[DW-1:0];
        last_drive_q <= drive_q[DW-1:0];
        last_error_q <= err_q;
        last_time_q  <= ts_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q   <= in_err;
      ts_q    <= in_ts;
      dt_q    <= dt_sel;
      esum_q  <= (DW+1)'(in_err) + (DW+1)'(last_error_q);
      ediff_q <= (DW+1)'(in_err) - (DW+1)'(last_error_q);
    end
    p_q     <= p_d;
    t_q     <= t_d;
    integ_q <= integ_d;
    d_q     <= d_d;
    drive_q <= drive_d;
    step_q  <= step_d;
    if (out_load) out_q <= drive_q[DW-1:0];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(unsigned'(out_q));

endmodule

`default_nettype wire

### hdl/pidr_mul_div.sv
// Bit-serial arithmetic unit: saturating shift-add multiplier and restoring divider.
// Depends on pidr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidr_mul_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire pidr_pkg::pidr_cmd_t                 cmd_i,
  input  wire logic signed [pidr_pkg::WIDE_W-1:0]  a_i,  // multiplicand / numerator
  input  wire logic signed [pidr_pkg::WIDE_W-1:0]  b_i,  // multiplier / positive divisor
  output pidr_pkg::pidr_stat_t                     stat_o,
  output logic signed [pidr_pkg::WIDE_W-1:0]       res_o
);
  import pidr_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [MAG_W-1:0]  mcand_q, mcand_d, mplier_q, mplier_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic              neg_q, neg_d, div_q, div_d, sh_q, sh_d;
  logic signed [WIDE_W-1:0] res_q, res_d;

  logic [WIDE_W-1:0] mag_a, mag_b;
  logic [DEN_W:0]    trial, den;
  logic              ge;
  logic [PROD_W-1:0] shifted;
  logic [SAT_W-1:0]  mag_r;

  always_comb begin
    mag_a   = a_i[WIDE_W-1] ? WIDE_W'(-a_i) : WIDE_W'(a_i);
    mag_b   = b_i[WIDE_W-1] ? WIDE_W'(-b_i) : WIDE_W'(b_i);
    trial   = {rem_q, mplier_q[MAG_W-1]};
    den     = {1'b0, mcand_q[DEN_W-1:0]};
    ge      = (trial >= den);
    shifted = sh_q ? (acc_q >> FRAC_BITS) : acc_q;
    if (div_q) mag_r = acc_q[SAT_W-1:0];
    else if (|shifted[PROD_W-1:SAT_W]) mag_r = '1;
    else mag_r = shifted[SAT_W-1:0];
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    div_d    = div_q;
    sh_d     = sh_q;
    res_d    = res_q;
    if (!busy_q && cmd_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = '0;
      acc_d    = '0;
      rem_d    = '0;
      div_d    = cmd_i.is_div;
      sh_d     = cmd_i.shift_frac;
      mcand_d  = cmd_i.is_div ? MAG_W'(b_i[DEN_W-1:0]) : mag_a[MAG_W-1:0];
      mplier_d = cmd_i.is_div ? mag_a[MAG_W-1:0] : mag_b[MAG_W-1:0];
      neg_d    = cmd_i.is_div ? a_i[WIDE_W-1] : (a_i[WIDE_W-1] ^ b_i[WIDE_W-1]);
    end else if (busy_q) begin
      if (cnt_q == CNT_W'(MAG_W)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -WIDE_W'(signed'({1'b0, mag_r})) : WIDE_W'(signed'({1'b0, mag_r}));
      end else begin
        cnt_d    = cnt_q + 1'b1;
        mplier_d = {mplier_q[MAG_W-2:0], 1'b0};
        if (div_q) begin
          acc_d = {acc_q[PROD_W-2:0], ge};
          rem_d = ge ? DEN_W'(trial - den) : trial[DEN_W-1:0];
        end else begin
          acc_d = {acc_q[PROD_W-2:0], 1'b0} +
                  (mplier_q[MAG_W-1] ? PROD_W'(mcand_q) : '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    neg_q    <= neg_d;
    div_q    <= div_d;
    sh_q     <= sh_d;
    res_q    <= res_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire
